/* hw/rtl/khps_pkg.sv */
package khps_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned STEP_W = 5;  // log2(HASH_W), width of the divider step counter

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    typedef logic [HASH_W-1:0] hash_t;

    // one FNV-1a round, product kept modulo 2^32
    function automatic hash_t fnv_round(input hash_t h, input logic [7:0] b);
        hash_t mixed;
        mixed = h ^ hash_t'(b);
        return mixed * FNV_PRIME;  // low word of a 32x32 product
    endfunction

endpackage

/* hw/rtl/khps_ifs.sv */
interface khps_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, key_byte, byte_valid, last, input ready);
    modport sink   (input valid, key_byte, byte_valid, last, output ready);
endinterface

interface khps_result_if;
    logic                     valid;
    logic                     ready;
    logic [khps_pkg::HASH_W-1:0] partition;
    logic                     bad_count;

    modport source (output valid, partition, bad_count, input ready);
    modport sink   (input valid, partition, bad_count, output ready);
endinterface

interface khps_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [khps_pkg::HASH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/key_hash_partition_select_top.sv */
// Channel     Dir  Payload                          Handshake
// item_in     in   key_byte[7:0] byte_valid last    valid/ready
// result_out  out  partition[31:0] bad_count        valid/ready
// cfg_wr      in   data[31:0] -> count_reg          valid/ready (ready tied high)
//
// A non-last item is absorbed in ST_IDLE (one FNV round through the multiplier).
// A last item with a nonzero count and non-empty key is accepted, then takes 32
// restoring-divide steps on the shared subtractor before ST_FIN loads the result
// register; an empty key or zero count skips the divide and goes to ST_FIN.
// item_in.ready is low while a key end is being divided; the result register
// lets new items in while an earlier result waits; a stalled result holds the
// final step. Reset: hash = FNV offset basis, count = 1, no result pending.
module key_hash_partition_select_top (
    input  logic              clk,
    input  logic              rst_n,
    khps_item_if.sink         item_in,
    khps_result_if.source     result_out,
    khps_cfg_if.sink          cfg_wr
);

    logic [1:0]                       state_reg, state_next;
    logic [khps_pkg::STEP_W-1:0]      step_reg, step_next;
    khps_pkg::hash_t                  hash_reg, hash_next;
    logic                             nonempty_reg, nonempty_next;
    khps_pkg::hash_t                  count_reg;
    khps_pkg::hash_t                  dvd_reg, dvd_next;     // dividend, shifted out MSB first
    khps_pkg::hash_t                  rem_reg, rem_next;     // partial remainder
    logic                             zero_reg, zero_next;   // result forced to 0
    logic                             bad_reg, bad_next;
    logic                             out_valid_reg, out_valid_next;
    khps_pkg::hash_t                  out_part_reg, out_part_next;
    logic                             out_bad_reg, out_bad_next;

    logic                             in_acc;
    khps_pkg::hash_t                  hash_upd;
    logic                             nonempty_upd;
    logic [khps_pkg::HASH_W:0]        rem_shift;
    logic [khps_pkg::HASH_W+1:0]      diff;
    logic                             out_free;

    assign item_in.ready = (state_reg == khps_pkg::ST_IDLE);
    assign in_acc        = item_in.valid && item_in.ready;
    assign cfg_wr.ready  = 1'b1;

    assign hash_upd     = item_in.byte_valid
                        ? khps_pkg::fnv_round(hash_reg, item_in.key_byte) : hash_reg;
    assign nonempty_upd = nonempty_reg | item_in.byte_valid;

    // shared shift-subtract unit: one quotient bit per cycle
    assign rem_shift = {rem_reg, dvd_reg[khps_pkg::HASH_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, count_reg};
    assign out_free  = !out_valid_reg || result_out.ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        hash_next      = hash_reg;
        nonempty_next  = nonempty_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        zero_next      = zero_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_part_next  = out_part_reg;
        out_bad_next   = out_bad_reg;

        case (state_reg)
            khps_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (item_in.last)
                    begin
                        // key end: hand the hash to the divider, restart the key
                        hash_next     = khps_pkg::FNV_BASIS;
                        nonempty_next = 1'b0;
                        dvd_next      = hash_upd;
                        rem_next      = '0;
                        step_next     = '0;
                        bad_next      = (count_reg == '0);
                        zero_next     = (count_reg == '0) || !nonempty_upd;
                        state_next    = zero_next ? khps_pkg::ST_FIN : khps_pkg::ST_DIV;
                    end
                    else
                    begin
                        hash_next     = hash_upd;
                        nonempty_next = nonempty_upd;
                    end
                end
            end
            khps_pkg::ST_DIV:
            begin
                rem_next  = diff[khps_pkg::HASH_W+1] ? rem_shift[khps_pkg::HASH_W-1:0]
                                                     : diff[khps_pkg::HASH_W-1:0];
                dvd_next  = {dvd_reg[khps_pkg::HASH_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == '1)
                    state_next = khps_pkg::ST_FIN;
            end
            khps_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_part_next  = zero_reg ? '0 : rem_reg;
                    out_bad_next   = bad_reg;
                    state_next     = khps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = khps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= khps_pkg::ST_IDLE;
            hash_reg      <= khps_pkg::FNV_BASIS;
            nonempty_reg  <= 1'b0;
            count_reg     <= khps_pkg::HASH_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr.valid && cfg_wr.ready)
                count_reg <= cfg_wr.data;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        zero_reg     <= zero_next;
        bad_reg      <= bad_next;
        out_part_reg <= out_part_next;
        out_bad_reg  <= out_bad_next;
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.partition = out_part_reg;
    assign result_out.bad_count = out_bad_reg;

    // ---- checks ----
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != khps_pkg::ST_IDLE) |-> !item_in.ready)
        else $error("item accepted while divider busy");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && item_in.last) |=> !item_in.ready)
        else $error("key end did not start the divider");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == khps_pkg::ST_FIN && !zero_reg) |-> (rem_reg < count_reg))
        else $error("remainder not below partition count");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> (out_part_reg == '0))
        else $error("bad count result with nonzero partition");

endmodule
